// ===== sv/iprt_lpm_pkg.sv =====
package iprt_lpm_pkg;

	// Table size default
	localparam int DEF_MAX_ENTRIES = 16;

	// Command codes
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_LOCAL_ADDR  = 2'd0;
	localparam logic [1:0] REG_DEF_NETMASK = 2'd1;
	localparam logic [1:0] REG_DEF_GATEWAY = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_OWN       = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_SHIFT,
		S_INSERT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] network;
		logic [31:0] mask;
		logic [31:0] gateway;
	} route_t;

endpackage

// ===== sv/ipv4_route_table_lpm_top.sv =====
// Channel | Signals                                   | Beat taken when
// in      | in_valid in_ready command address mask     | in_valid & in_ready
//         | gateway_in                                 |
// out     | out_valid out_ready status next_hop        | out_valid & out_ready
//         | route_used                                 |
// cfg     | cfg_we cfg_index cfg_wdata                 | cfg_we
//
// One beat at a time: in_ready is high only while idle. A lookup walks the table, one
// table read per cycle; add of a new route scans, shifts every entry up one slot, then
// inserts; add of a known route scans, then updates its gateway; delete scans, then on a
// hit shifts every entry behind it down one slot; full table, own address and unused
// command go straight to the result.
// Reset empties the table through the entry count; a stalled result holds the final state.
module ipv4_route_table_lpm_top
	import iprt_lpm_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] address,
	input  logic [31:0] mask,
	input  logic [31:0] gateway_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] next_hop,
	output logic        route_used,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	// Leading-ones thermometer of a mask: smear the zeros downward, invert
	function automatic logic [31:0] lead_therm(input logic [31:0] m);
		logic [31:0] z;
		z = ~m;
		z = z | (z >> 1);
		z = z | (z >> 2);
		z = z | (z >> 4);
		z = z | (z >> 8);
		z = z | (z >> 16);
		return ~z;
	endfunction

	state_t state_q, state_d;

	logic [31:0] local_addr_q, def_netmask_q, def_gateway_q;

	logic [1:0]       cmd_q;
	logic [31:0]      addr_q, mask_q, net_q, gw_q;
	status_t          stat_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             sc_vld_s1;
	logic [IDX_W-1:0] sc_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             best_vld_q;
	logic [31:0]      best_therm_q, best_gw_q;
	logic [CNT_W-1:0] src_q, left_q;
	logic             sh_vld_s1;
	logic [IDX_W-1:0] sh_dst_s1;

	route_t           mem_q [MAX_ENTRIES];
	route_t           rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	route_t           mem_wd;

	logic             out_valid_q, used_q;
	logic [1:0]       status_q;
	logic [31:0]      hop_q;

	logic             in_fire, out_free;
	logic             scan_issue, scan_done, shift_issue, shift_done;
	logic             entry_hit, entry_match, entry_longer;
	logic [31:0]      cand_therm;
	logic [CNT_W-1:0] shift_dst;
	logic             fin_used;
	logic [31:0]      fin_hop;
	status_t          accept_stat;
	logic             cmd_is_add;

	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign cmd_is_add = (cmd_q == CMD_ADD);

	assign scan_issue  = (state_q == S_SCAN) && (idx_q < cnt_q);
	assign scan_done   = (state_q == S_SCAN) && !scan_issue && !sc_vld_s1;
	assign shift_issue = (state_q == S_SHIFT) && (left_q != '0);
	assign shift_done  = (state_q == S_SHIFT) && (left_q == '0) && !sh_vld_s1;
	assign shift_dst   = cmd_is_add ? (src_q + CNT_W'(1)) : (src_q - CNT_W'(1));

	// Compare the entry read last cycle
	assign entry_hit    = (rd_data_q.network == net_q) && (rd_data_q.mask == mask_q);
	assign entry_match  = ((addr_q & rd_data_q.mask) == rd_data_q.network);
	assign cand_therm   = lead_therm(rd_data_q.mask);
	assign entry_longer = !best_vld_q || ((cand_therm & ~best_therm_q) != 32'd0);

	// Classify the incoming beat
	always_comb begin
		accept_stat = ST_OK;
		if ((command == CMD_LOOKUP) && (address == local_addr_q))
			accept_stat = ST_OWN;
		else if ((command == CMD_ADD) && (cnt_q >= CNT_MAX))
			accept_stat = ST_FULL;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (accept_stat != ST_OK)
						state_d = S_FINISH;
					else if ((command == CMD_LOOKUP) || (command == CMD_ADD) ||
						(command == CMD_DELETE))
						state_d = S_SCAN;
					else
						state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					if (cmd_q == CMD_ADD)
						state_d = hit_q ? S_UPDATE : S_SHIFT;
					else if ((cmd_q == CMD_DELETE) && hit_q)
						state_d = S_SHIFT;
					else
						state_d = S_FINISH;
				end
			end
			S_UPDATE: state_d = S_FINISH;
			S_SHIFT: begin
				if (shift_done)
					state_d = cmd_is_add ? S_INSERT : S_FINISH;
			end
			S_INSERT: state_d = S_FINISH;
			S_FINISH: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, table port, final result
	always_comb begin
		in_ready = (state_q == S_IDLE);
		rd_addr  = (state_q == S_SHIFT) ? src_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
		mem_we   = 1'b0;
		mem_wa   = hit_idx_q;
		mem_wd   = '{network: net_q, mask: mask_q, gateway: gw_q};
		unique case (state_q)
			S_UPDATE: mem_we = 1'b1;
			S_SHIFT: begin
				mem_we = sh_vld_s1;
				mem_wa = sh_dst_s1;
				mem_wd = rd_data_q;
			end
			S_INSERT: begin
				mem_we = 1'b1;
				mem_wa = '0;
			end
			default: mem_we = 1'b0;
		endcase

		fin_used = 1'b0;
		fin_hop  = 32'd0;
		if ((cmd_q == CMD_LOOKUP) && (stat_q == ST_OK)) begin
			fin_used = best_vld_q;
			fin_hop  = addr_q;
			if (best_vld_q) begin
				if (best_gw_q != 32'd0)
					fin_hop = best_gw_q;
			end else if ((def_netmask_q != 32'd0) && (def_gateway_q != 32'd0) &&
				((local_addr_q & def_netmask_q) != (addr_q & def_netmask_q))) begin
				fin_hop = def_gateway_q;
			end
		end
	end

	// Route table storage
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa] <= mem_wd;
		rd_data_q <= mem_q[rd_addr];
	end

	// Control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			sc_vld_s1     <= 1'b0;
			sh_vld_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
			local_addr_q  <= 32'd0;
			def_netmask_q <= 32'd0;
			def_gateway_q <= 32'd0;
		end else begin
			state_q   <= state_d;
			sc_vld_s1 <= scan_issue;
			sh_vld_s1 <= shift_issue;
			if (state_q == S_INSERT)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (shift_done && !cmd_is_add)
				cnt_q <= cnt_q - CNT_W'(1);
			if ((state_q == S_FINISH) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_LOCAL_ADDR:  local_addr_q  <= cfg_wdata;
					REG_DEF_NETMASK: def_netmask_q <= cfg_wdata;
					REG_DEF_GATEWAY: def_gateway_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// Command, scan and shift datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q      <= command;
			addr_q     <= address;
			mask_q     <= mask;
			net_q      <= address & mask;
			gw_q       <= gateway_in;
			stat_q     <= accept_stat;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			best_vld_q <= 1'b0;
		end

		// Walk the table, one entry per cycle
		if (scan_issue)
			idx_q <= idx_q + CNT_W'(1);
		sc_idx_s1 <= idx_q[IDX_W-1:0];
		if (sc_vld_s1) begin
			if (cmd_q == CMD_LOOKUP) begin
				if (entry_match && entry_longer) begin
					best_vld_q   <= 1'b1;
					best_therm_q <= cand_therm;
					best_gw_q    <= rd_data_q.gateway;
				end
			end else if (!hit_q && entry_hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= sc_idx_s1;
			end
		end

		// Set up the shift once the walk ends
		if (scan_done) begin
			if (cmd_is_add) begin
				src_q  <= cnt_q - CNT_W'(1);
				left_q <= cnt_q;
			end else if (cmd_q == CMD_DELETE) begin
				src_q  <= CNT_W'(hit_idx_q) + CNT_W'(1);
				left_q <= cnt_q - CNT_W'(hit_idx_q) - CNT_W'(1);
				if (!hit_q)
					stat_q <= ST_NOT_FOUND;
			end
		end

		// Move one entry per cycle: up for add, down for delete
		if (shift_issue) begin
			src_q     <= cmd_is_add ? (src_q - CNT_W'(1)) : (src_q + CNT_W'(1));
			left_q    <= left_q - CNT_W'(1);
		end
		sh_dst_s1 <= shift_dst[IDX_W-1:0];

		// Capture the result
		if ((state_q == S_FINISH) && out_free) begin
			status_q <= stat_q;
			hop_q    <= fin_hop;
			used_q   <= fin_used;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign next_hop   = hop_q;
	assign route_used = used_q;

endmodule

// ===== sv/iprt_lpm_checker.sv =====
module iprt_lpm_checker
	import iprt_lpm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic [31:0] address,
	input logic [31:0] mask,
	input logic [31:0] gateway_in,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] next_hop,
	input logic        route_used,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [31:0] cfg_wdata
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(next_hop) && $stable(route_used))
		else $error("stalled result beat changed");

	// Go busy after taking a command beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a command beat");

	// Failed commands carry no next hop and no route
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (next_hop == 32'd0) && !route_used)
		else $error("failed command returned a next hop");

	// A used route means the command succeeded
	a_used_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && route_used |-> (status == ST_OK))
		else $error("route used on a failed command");

endmodule

bind ipv4_route_table_lpm_top iprt_lpm_checker u_iprt_lpm_checker (.*);

// ===== verif/tb.sv =====
module tb;
	import iprt_lpm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD   = 10;
	localparam int          TBL_DEPTH    = DEF_MAX_ENTRIES;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          PHASES       = 6;
	localparam int          PHASE_BEATS  = 240;
	localparam int          BURST_LEN    = 40;
	localparam int          POOL_N       = 6;
	localparam int          SETTLE_WAIT  = 64;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [1:0]  REG_UNUSED   = 2'd3;

	typedef struct packed {
		status_t     status;
		logic [31:0] next_hop;
		logic        route_used;
	} route_result_t;

	// ROW_REG writes a register, ROW_CHK carries its own expected result,
	// ROW_PRED is checked against the table predictor
	typedef enum logic [1:0] {
		ROW_REG,
		ROW_CHK,
		ROW_PRED
	} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [1:0]    sel;
		logic [31:0]   addr;
		logic [31:0]   msk;
		logic [31:0]   gw;
		route_result_t want;
	} dir_row_t;

	localparam route_result_t RES_ZERO = '{ST_OK, 32'h0, 1'b0};
	localparam route_result_t RES_MISS = '{ST_NOT_FOUND, 32'h0, 1'b0};
	localparam route_result_t RES_OWN  = '{ST_OWN, 32'h0, 1'b0};
	localparam int            DIR_ROWS = 26;

	// Directed sequence: empty table at reset config, fallback, own address,
	// add/update/delete, prefix ties, default route, host route
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_CHK,  CMD_LOOKUP,      32'h00000000, 32'h00000000, 32'h00000000, RES_OWN},
		'{ROW_CHK,  CMD_LOOKUP,      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			'{ST_OK, 32'hFFFFFFFF, 1'b0}},
		'{ROW_CHK,  CMD_DELETE,      32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, RES_MISS},
		'{ROW_CHK,  CMD_UNUSED,      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, RES_ZERO},
		'{ROW_REG,  REG_LOCAL_ADDR,  32'hC0A80001, 32'h0, 32'h0, RES_ZERO},
		'{ROW_REG,  REG_DEF_NETMASK, 32'hFFFFFF00, 32'h0, 32'h0, RES_ZERO},
		'{ROW_REG,  REG_DEF_GATEWAY, 32'hC0A800FE, 32'h0, 32'h0, RES_ZERO},
		'{ROW_REG,  REG_UNUSED,      32'hFFFFFFFF, 32'h0, 32'h0, RES_ZERO},
		'{ROW_CHK,  CMD_LOOKUP,      32'h08080808, 32'h00000000, 32'h00000000,
			'{ST_OK, 32'hC0A800FE, 1'b0}},
		'{ROW_CHK,  CMD_LOOKUP,      32'hC0A80005, 32'h00000000, 32'h00000000,
			'{ST_OK, 32'hC0A80005, 1'b0}},
		'{ROW_CHK,  CMD_LOOKUP,      32'hC0A80001, 32'hFFFFFFFF, 32'h00000000, RES_OWN},
		'{ROW_CHK,  CMD_ADD,         32'h0A0B0C0D, 32'hFF000000, 32'h0A000001, RES_ZERO},
		'{ROW_CHK,  CMD_ADD,         32'h0A0B0C0D, 32'hFFFF0000, 32'h00000000, RES_ZERO},
		'{ROW_CHK,  CMD_LOOKUP,      32'h0A0B0102, 32'h00000000, 32'h00000000,
			'{ST_OK, 32'h0A0B0102, 1'b1}},
		'{ROW_CHK,  CMD_LOOKUP,      32'h0A010101, 32'h00000000, 32'h00000000,
			'{ST_OK, 32'h0A000001, 1'b1}},
		'{ROW_CHK,  CMD_ADD,         32'h0AFFFFFF, 32'hFF000000, 32'h0A000002, RES_ZERO},
		'{ROW_CHK,  CMD_LOOKUP,      32'h0A010101, 32'h00000000, 32'h00000000,
			'{ST_OK, 32'h0A000002, 1'b1}},
		'{ROW_PRED, CMD_ADD,         32'h0A00AB00, 32'hFF00FF00, 32'h0B000001, RES_ZERO},
		'{ROW_PRED, CMD_LOOKUP,      32'h0A0CAB01, 32'h00000000, 32'h00000000, RES_ZERO},
		'{ROW_PRED, CMD_ADD,         32'hFFFFFFFF, 32'h00000000, 32'h00000000, RES_ZERO},
		'{ROW_PRED, CMD_LOOKUP,      32'h08080808, 32'h00000000, 32'h00000000, RES_ZERO},
		'{ROW_PRED, CMD_ADD,         32'h08080808, 32'hFFFFFFFF, 32'hFFFFFFFF, RES_ZERO},
		'{ROW_PRED, CMD_LOOKUP,      32'h08080808, 32'h00000000, 32'h00000000, RES_ZERO},
		'{ROW_PRED, CMD_DELETE,      32'h0A123456, 32'hFF000000, 32'h00000000, RES_ZERO},
		'{ROW_CHK,  CMD_DELETE,      32'h0A123456, 32'hFF000000, 32'h00000000, RES_MISS},
		'{ROW_PRED, CMD_LOOKUP,      32'h0A010101, 32'h00000000, 32'h00000000, RES_ZERO}
	};

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [1:0]  command    = CMD_LOOKUP;
	logic [31:0] address    = 32'h0;
	logic [31:0] mask       = 32'h0;
	logic [31:0] gateway_in = 32'h0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [1:0]  status;
	logic [31:0] next_hop;
	logic        route_used;
	logic        cfg_we     = 1'b0;
	logic [1:0]  cfg_index  = REG_LOCAL_ADDR;
	logic [31:0] cfg_wdata  = 32'h0;

	// Predictor state: route table newest first, plus register copies
	logic [31:0]   tbl_net  [TBL_DEPTH];
	logic [31:0]   tbl_mask [TBL_DEPTH];
	logic [31:0]   tbl_gw   [TBL_DEPTH];
	int            tbl_count   = 0;
	logic [31:0]   cfg_local   = 32'h0;
	logic [31:0]   cfg_netmask = 32'h0;
	logic [31:0]   cfg_gateway = 32'h0;

	route_result_t pending_results [$];
	int            send_idle_pct = 11;
	int            recv_idle_pct = 59;
	int            fail_count    = 0;

	ipv4_route_table_lpm_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.address    (address),
		.mask       (mask),
		.gateway_in (gateway_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.next_hop   (next_hop),
		.route_used (route_used),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [31:0] prefix_mask(int unsigned len);
		return (len == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - len));
	endfunction

	function automatic int leading_ones(logic [31:0] m);
		int n;
		n = 0;
		while (m[31]) begin
			n++;
			m = m << 1;
		end
		return n;
	endfunction

	// Apply one command to the predicted table and return its result
	function automatic route_result_t route_cmd_result(logic [1:0] cmd, logic [31:0] dst,
			logic [31:0] msk, logic [31:0] gw);
		route_result_t r;
		logic [31:0]   net;
		int            hit;
		int            best;
		int            best_len;
		int            len;
		r   = RES_ZERO;
		net = dst & msk;
		hit = -1;
		for (int i = 0; i < tbl_count; i++) begin
			if (hit < 0 && tbl_net[i] == net && tbl_mask[i] == msk)
				hit = i;
		end
		case (cmd)
			CMD_LOOKUP: begin
				if (dst == cfg_local) begin
					r.status = ST_OWN;
				end else begin
					best     = -1;
					best_len = -1;
					// longest prefix wins, first (newest) entry on ties
					for (int i = 0; i < tbl_count; i++) begin
						if ((dst & tbl_mask[i]) == tbl_net[i]) begin
							len = leading_ones(tbl_mask[i]);
							if (len > best_len) begin
								best_len = len;
								best     = i;
							end
						end
					end
					r.next_hop = dst;
					if (best >= 0) begin
						r.route_used = 1'b1;
						if (tbl_gw[best] != 32'h0)
							r.next_hop = tbl_gw[best];
					end else if (cfg_netmask != 32'h0 && cfg_gateway != 32'h0 &&
							(cfg_local & cfg_netmask) != (dst & cfg_netmask)) begin
						r.next_hop = cfg_gateway;
					end
				end
			end
			CMD_ADD: begin
				if (tbl_count >= TBL_DEPTH) begin
					r.status = ST_FULL;
				end else if (hit >= 0) begin
					tbl_gw[hit] = gw;
				end else begin
					// push every entry back one slot, insert at the front
					for (int i = tbl_count; i > 0; i--) begin
						tbl_net[i]  = tbl_net[i - 1];
						tbl_mask[i] = tbl_mask[i - 1];
						tbl_gw[i]   = tbl_gw[i - 1];
					end
					tbl_net[0]  = net;
					tbl_mask[0] = msk;
					tbl_gw[0]   = gw;
					tbl_count++;
				end
			end
			CMD_DELETE: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// close the gap behind the removed entry
					for (int i = hit; i < tbl_count - 1; i++) begin
						tbl_net[i]  = tbl_net[i + 1];
						tbl_mask[i] = tbl_mask[i + 1];
						tbl_gw[i]   = tbl_gw[i + 1];
					end
					tbl_count--;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Offer one beat after a random gap; predict once it is taken
	task automatic send_beat(input logic [1:0] cmd, input logic [31:0] dst,
			input logic [31:0] msk, input logic [31:0] gw, input logic typed,
			input route_result_t typed_res);
		route_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		address    <= dst;
		mask       <= msk;
		gateway_in <= gw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = route_cmd_result(cmd, dst, msk, gw);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	// Drop valid and hold until every pending result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_LOCAL_ADDR:  cfg_local   = val;
			REG_DEF_NETMASK: cfg_netmask = val;
			REG_DEF_GATEWAY: cfg_gateway = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Check each result beat against the oldest pending one; stall at random
	always @(posedge clk) begin : result_check
		route_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending: status %0d next_hop %h",
					status, next_hop);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (next_hop !== want.next_hop) begin
					$error("next_hop: expected %h, got %h", want.next_hop, next_hop);
					fail_count++;
				end
				if (route_used !== want.route_used) begin
					$error("route_used: expected %0d, got %0d", want.route_used, route_used);
					fail_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("ipv4_route_table_lpm_top test failed");
		$finish;
	end

	initial begin : stimulus
		logic [1:0]  cmd;
		logic [31:0] dst;
		logic [31:0] msk;
		logic [31:0] gw;
		logic [31:0] la;
		logic [31:0] nm;
		logic [31:0] gwv;
		logic [31:0] pool [POOL_N];
		int unsigned pick;
		int unsigned e;
		bit          heavy_add;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				drain();
				write_reg(dir_rows[i].sel, dir_rows[i].addr);
			end else begin
				send_beat(dir_rows[i].sel, dir_rows[i].addr, dir_rows[i].msk,
					dir_rows[i].gw, dir_rows[i].kind == ROW_CHK, dir_rows[i].want);
			end
		end

		// Random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					la = $urandom; nm = 32'hFFFFFF00; gwv = $urandom;
				end
				1: begin
					la = 32'hFFFFFFFF; nm = 32'hFFFFFFFF; gwv = 32'hFFFFFFFF;
				end
				2: begin
					la = $urandom; nm = 32'h0; gwv = $urandom;
				end
				3: begin
					la = $urandom; nm = 32'hFFFF0000; gwv = 32'h0;
				end
				4: begin
					la = 32'h0; nm = 32'h0; gwv = 32'h0;
				end
				default: begin
					la = $urandom; nm = prefix_mask($urandom_range(32)); gwv = $urandom;
				end
			endcase
			write_reg(REG_LOCAL_ADDR, la);
			write_reg(REG_DEF_NETMASK, nm);
			write_reg(REG_DEF_GATEWAY, gwv);

			// receiver sparse first, then sender sparse, then full rate
			if (ph < 2) begin
				send_idle_pct = 11;
				recv_idle_pct = 59;
			end else if (ph < 4) begin
				send_idle_pct = 59;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			// POOL_N base networks, the local address first, so that nearby routes overlap and collide
			pool[0] = la;
			for (int k = 1; k < POOL_N; k++)
				pool[k] = $urandom;

			for (int n = 0; n < PHASE_BEATS; n++) begin
				// alternate fill bursts and drain bursts
				heavy_add = ((n / BURST_LEN) % 2) == 0;
				pick = $urandom_range(99);
				if (pick < 3)
					cmd = CMD_UNUSED;
				else if (pick < (heavy_add ? 45 : 15))
					cmd = CMD_ADD;
				else if (pick < 57)
					cmd = CMD_DELETE;
				else
					cmd = CMD_LOOKUP;

				msk = ($urandom_range(99) < 85) ? prefix_mask($urandom_range(32)) : $urandom;
				if ($urandom_range(3) == 0)
					dst = $urandom;
				else
					dst = pool[$urandom_range(POOL_N - 1)] ^ ($urandom & 32'h0000FFFF);
				gw = ($urandom_range(3) == 0) ? 32'h0 : $urandom;

				pick = $urandom_range(99);
				e = (tbl_count > 0) ? $urandom_range(tbl_count - 1) : 0;
				case (cmd)
					CMD_ADD: begin
						// existing route: gateway update, or refused when full
						if (tbl_count > 0 && pick < 25) begin
							dst = tbl_net[e] | ($urandom & ~tbl_mask[e]);
							msk = tbl_mask[e];
						end
					end
					CMD_DELETE: begin
						if (tbl_count > 0 && pick < 60) begin
							dst = tbl_net[e] | ($urandom & ~tbl_mask[e]);
							msk = tbl_mask[e];
						end else if (tbl_count > 0 && pick < 80) begin
							dst = tbl_net[e];
						end
					end
					CMD_LOOKUP: begin
						if (tbl_count > 0 && pick < 45)
							dst = tbl_net[e] | ($urandom & ~tbl_mask[e]);
						else if (pick < 55)
							dst = cfg_local;
						else if (pick < 65)
							dst = cfg_local ^ ($urandom & 32'h000000FF);
					end
					default: ;
				endcase
				send_beat(cmd, dst, msk, gw, 1'b0, RES_ZERO);
			end
		end

		drain();
		repeat (SETTLE_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("ipv4_route_table_lpm_top test passed");
		else
			$display("ipv4_route_table_lpm_top test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/iprt_lpm_pkg.sv
sv/ipv4_route_table_lpm_top.sv
sv/iprt_lpm_checker.sv
verif/tb.sv
